// ===== src/slt_pkg.sv =====
`default_nettype none
package slt_pkg;

    // field widths
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned POS_W   = 12;

    // default line length bound
    localparam int unsigned LINE_LENGTH_MAX_DEF = 4096;

    // token counter ceiling
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SQ    = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQ    = 8'h22;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3e;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3c;
    localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7c;

    // operator of the current run
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_GT   = 2'd1,
        OP_LT   = 2'd2,
        OP_PIPE = 2'd3
    } op_code_t;

    // scanner modes, one-hot
    typedef enum logic [4:0] {
        MODE_GAP  = 5'b00001,
        MODE_WORD = 5'b00010,
        MODE_SQ   = 5'b00100,
        MODE_DQ   = 5'b01000,
        MODE_OP   = 5'b10000
    } scan_mode_t;

    // line scanning state
    typedef struct packed {
        scan_mode_t         mode;
        op_code_t           run_op;
        logic [COUNT_W-1:0] seen;
        logic [POS_W-1:0]   pos;
    } scan_state_t;

    // per-character result
    typedef struct packed {
        logic [CHAR_W-1:0]  ch_out;
        logic               in_token;
        logic               token_start;
        logic [COUNT_W-1:0] token_index;
        logic [POS_W-1:0]   char_offset;
        logic               line_end;
        logic [COUNT_W-1:0] token_total;
    } scan_result_t;

    // map a character to its operator code
    function automatic op_code_t op_of(input logic [CHAR_W-1:0] c);
        op_code_t r;
        r = OP_NONE;
        if (c == CH_GT) r = OP_GT;
        else if (c == CH_LT) r = OP_LT;
        else if (c == CH_PIPE) r = OP_PIPE;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/slt_scan.sv =====
`default_nettype none
module slt_scan #(
    parameter int unsigned LINE_LENGTH_MAX = slt_pkg::LINE_LENGTH_MAX_DEF
) (
    input  wire slt_pkg::scan_state_t                  cur,
    input  wire logic [slt_pkg::CHAR_W-1:0]            ch,
    input  wire logic                                  last_char,
    output slt_pkg::scan_state_t                       nxt,
    output slt_pkg::scan_result_t                      res
);

    localparam int unsigned LEN_CAP =
        (LINE_LENGTH_MAX > 4096) ? 4096 : ((LINE_LENGTH_MAX < 1) ? 1 : LINE_LENGTH_MAX);
    localparam logic [slt_pkg::POS_W-1:0] POS_LIMIT = slt_pkg::POS_W'(LEN_CAP - 1);

    slt_pkg::op_code_t                  op;
    slt_pkg::scan_mode_t                mode_next;
    slt_pkg::op_code_t                  run_op_next;
    logic                               member;
    logic                               start;
    logic [slt_pkg::COUNT_W-1:0]        seen_next;
    logic [slt_pkg::POS_W-1:0]          pos_next;

    assign op = slt_pkg::op_of(ch);

    // mode transitions and token boundaries
    always_comb
    begin
        mode_next   = cur.mode;
        run_op_next = cur.run_op;
        member      = 1'b1;
        start       = 1'b0;
        case (cur.mode)
            slt_pkg::MODE_SQ:
            begin
                if (ch == slt_pkg::CH_SQ) mode_next = slt_pkg::MODE_WORD;
            end
            slt_pkg::MODE_DQ:
            begin
                if (ch == slt_pkg::CH_DQ) mode_next = slt_pkg::MODE_WORD;
            end
            default:
            begin
                if (ch == slt_pkg::CH_SPACE)
                begin
                    member      = 1'b0;
                    mode_next   = slt_pkg::MODE_GAP;
                    run_op_next = slt_pkg::OP_NONE;
                end
                else if (op != slt_pkg::OP_NONE)
                begin
                    start       = !(cur.mode == slt_pkg::MODE_OP && cur.run_op == op);
                    mode_next   = slt_pkg::MODE_OP;
                    run_op_next = op;
                end
                else
                begin
                    start       = (cur.mode != slt_pkg::MODE_WORD);
                    run_op_next = slt_pkg::OP_NONE;
                    if (ch == slt_pkg::CH_SQ) mode_next = slt_pkg::MODE_SQ;
                    else if (ch == slt_pkg::CH_DQ) mode_next = slt_pkg::MODE_DQ;
                    else mode_next = slt_pkg::MODE_WORD;
                end
            end
        endcase
    end

    // saturating token count and position
    assign seen_next = (start && cur.seen < slt_pkg::COUNT_MAX) ?
                       cur.seen + slt_pkg::COUNT_W'(1) : cur.seen;
    assign pos_next  = (cur.pos < POS_LIMIT) ? cur.pos + slt_pkg::POS_W'(1) : POS_LIMIT;

    // result fields
    always_comb
    begin
        res.ch_out      = ch;
        res.in_token    = member;
        res.token_start = start;
        res.token_index = (member && seen_next != '0) ?
                          seen_next - slt_pkg::COUNT_W'(1) : '0;
        res.char_offset = (cur.pos > POS_LIMIT) ? POS_LIMIT : cur.pos;
        res.line_end    = last_char;
        res.token_total = last_char ? seen_next : '0;
    end

    // state after this character, back to idle at the end of a line
    always_comb
    begin
        if (last_char)
        begin
            nxt.mode   = slt_pkg::MODE_GAP;
            nxt.run_op = slt_pkg::OP_NONE;
            nxt.seen   = '0;
            nxt.pos    = '0;
        end
        else
        begin
            nxt.mode   = mode_next;
            nxt.run_op = run_op_next;
            nxt.seen   = seen_next;
            nxt.pos    = pos_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/shell_line_token_splitter_top.sv =====
// each accepted input beat gives a registered result beat in the cycle after it is taken
// throughput: one character per cycle while the input is not stalled, set by the combinational scanner update
// the input is stalled only while a result is held and the output is stalled
// reset (rst_n low, asynchronous) clears the scanner state and the result valid
// after the last character of a line the scanner returns to its reset state
`default_nettype none
module shell_line_token_splitter_top #(
    parameter int unsigned LINE_LENGTH_MAX = slt_pkg::LINE_LENGTH_MAX_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [slt_pkg::CHAR_W-1:0]           ch,
    input  wire logic                                 last_char,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [slt_pkg::CHAR_W-1:0]                ch_out,
    output logic                                      in_token,
    output logic                                      token_start,
    output logic [slt_pkg::COUNT_W-1:0]               token_index,
    output logic [slt_pkg::POS_W-1:0]                 char_offset,
    output logic                                      line_end,
    output logic [slt_pkg::COUNT_W-1:0]               token_total
);

    slt_pkg::scan_state_t  state_reg;
    slt_pkg::scan_state_t  state_next;
    slt_pkg::scan_result_t res_next;
    slt_pkg::scan_result_t res_reg;
    logic                  valid_reg;
    logic                  in_fire;

    // input taken when the result register is free or draining
    assign in_stall = valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    slt_scan #(
        .LINE_LENGTH_MAX (LINE_LENGTH_MAX)
    ) u_scan (
        .cur       (state_reg),
        .ch        (ch),
        .last_char (last_char),
        .nxt       (state_next),
        .res       (res_next)
    );

    // scanner state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode   <= slt_pkg::MODE_GAP;
            state_reg.run_op <= slt_pkg::OP_NONE;
            state_reg.seen   <= '0;
            state_reg.pos    <= '0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            if (in_fire) state_reg <= state_next;
            if (in_fire) valid_reg <= 1'b1;
            else if (!out_stall) valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire) res_reg <= res_next;
    end

    // output beat
    assign out_valid   = valid_reg;
    assign ch_out      = res_reg.ch_out;
    assign in_token    = res_reg.in_token;
    assign token_start = res_reg.token_start;
    assign token_index = res_reg.token_index;
    assign char_offset = res_reg.char_offset;
    assign line_end    = res_reg.line_end;
    assign token_total = res_reg.token_total;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import slt_pkg::*;

    localparam int unsigned LINE_LEN        = LINE_LENGTH_MAX_DEF;
    localparam int unsigned OFFSET_CAP      = (LINE_LEN > 4096 ? 4096 : LINE_LEN) - 1;
    localparam int unsigned RANDOM_CHARS    = 280;
    localparam int unsigned LONG_LINE_CHARS = 1050;
    localparam int unsigned OP_TOKEN_CHARS  = 1030;
    localparam int unsigned STALL_PHASE     = 48;
    localparam int unsigned DRAIN_LIMIT     = 1000;
    localparam int unsigned REPORT_LIMIT    = 10;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE        = 2'd0,
        RX_LIGHT       = 2'd1,
        RX_HEAVY       = 2'd2,
        RX_EVERY_THIRD = 2'd3
    } rx_pattern_t;

    // one character beat waiting to be sent
    typedef struct packed {
        logic [CHAR_W-1:0] c;
        logic              last;
    } char_beat_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [CHAR_W-1:0]  ch        = '0;
    logic               last_char = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CHAR_W-1:0]  ch_out;
    logic               in_token;
    logic               token_start;
    logic [COUNT_W-1:0] token_index;
    logic [POS_W-1:0]   char_offset;
    logic               line_end;
    logic [COUNT_W-1:0] token_total;

    char_beat_t   line_chars[$];
    scan_result_t scan_expected[$];
    char_beat_t   next_beat;
    scan_result_t seen_result;
    scan_result_t wanted_result;
    int unsigned  mismatches  = 0;
    int unsigned  burst_left  = 1;
    int unsigned  gap_left    = 0;
    int unsigned  stall_cycle = 0;
    rx_pattern_t  rx_pattern  = RX_FREE;

    // scanner state as the splitter should hold it
    scan_mode_t         cur_mode    = MODE_GAP;
    op_code_t           cur_op      = OP_NONE;
    logic [COUNT_W-1:0] token_count = '0;
    logic [POS_W-1:0]   next_offset = '0;

    shell_line_token_splitter_top #(
        .LINE_LENGTH_MAX(LINE_LEN)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ch_out     (ch_out),
        .in_token   (in_token),
        .token_start(token_start),
        .token_index(token_index),
        .char_offset(char_offset),
        .line_end   (line_end),
        .token_total(token_total)
    );

    always #5 clk = ~clk;

    // tag one character and advance the scanner state
    function automatic scan_result_t scan_char(input logic [CHAR_W-1:0] c, input logic last);
        scan_result_t r;
        op_code_t     op;
        logic         member;
        logic         start;
        case (c)
            CH_GT:   op = OP_GT;
            CH_LT:   op = OP_LT;
            CH_PIPE: op = OP_PIPE;
            default: op = OP_NONE;
        endcase
        member = 1'b1;
        start = 1'b0;
        r.char_offset = next_offset;
        if (cur_mode == MODE_SQ)
        begin
            if (c == CH_SQ)
                cur_mode = MODE_WORD;
        end
        else if (cur_mode == MODE_DQ)
        begin
            if (c == CH_DQ)
                cur_mode = MODE_WORD;
        end
        else if (c == CH_SPACE)
        begin
            member = 1'b0;
            cur_mode = MODE_GAP;
            cur_op = OP_NONE;
        end
        else if (op != OP_NONE)
        begin
            // a new operator run unless the same operator continues
            if (!(cur_mode == MODE_OP && cur_op == op))
                start = 1'b1;
            cur_mode = MODE_OP;
            cur_op = op;
        end
        else
        begin
            if (cur_mode != MODE_WORD)
                start = 1'b1;
            cur_op = OP_NONE;
            if (c == CH_SQ)
                cur_mode = MODE_SQ;
            else if (c == CH_DQ)
                cur_mode = MODE_DQ;
            else
                cur_mode = MODE_WORD;
        end
        if (start && token_count != COUNT_MAX)
            token_count = token_count + COUNT_W'(1);
        r.ch_out = c;
        r.in_token = member;
        r.token_start = start;
        r.token_index = (member && token_count != '0) ? token_count - COUNT_W'(1) : '0;
        r.line_end = last;
        r.token_total = last ? token_count : '0;
        if (next_offset != POS_W'(OFFSET_CAP))
            next_offset = next_offset + POS_W'(1);
        // the line is over, back to the idle state
        if (last)
        begin
            cur_mode = MODE_GAP;
            cur_op = OP_NONE;
            token_count = '0;
            next_offset = '0;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char(input logic [CHAR_W-1:0] prev);
        int unsigned       roll;
        logic [CHAR_W-1:0] c;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            c = 8'h61 + CHAR_W'($urandom_range(0, 25));
        else if (roll < 55)
            c = CH_SPACE;
        else if (roll < 72)
        begin
            // repeat the previous operator half the time to build runs
            if ((prev == CH_GT || prev == CH_LT || prev == CH_PIPE) && $urandom_range(0, 1))
                c = prev;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       c = CH_GT;
                    1:       c = CH_LT;
                    default: c = CH_PIPE;
                endcase
            end
        end
        else if (roll < 80)
            c = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        else
            c = CHAR_W'($urandom_range(1, 255));
        return c;
    endfunction

    task automatic add_char(input logic [CHAR_W-1:0] c, input logic last);
        char_beat_t b;
        b.c = c;
        b.last = last;
        line_chars.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endtask

    // mostly command-like lines, some raw byte noise
    task automatic add_random_lines(input int unsigned total);
        int unsigned       done;
        int unsigned       len;
        bit                noisy;
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] prev;
        done = 0;
        while (done < total)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            noisy = ($urandom_range(0, 4) == 0);
            prev = CH_SPACE;
            for (int unsigned i = 0; i < len; i++)
            begin
                c = noisy ? CHAR_W'($urandom_range(1, 255)) : pick_char(prev);
                add_char(c, i == len - 1);
                prev = c;
            end
            done += len;
        end
    endtask

    task automatic show_result(input string tag, input scan_result_t r);
        $display("  %s: ch=%02h in_token=%0d start=%0d index=%0d offset=%0d end=%0d total=%0d",
                 tag, r.ch_out, r.in_token, r.token_start, r.token_index, r.char_offset,
                 r.line_end, r.token_total);
    endtask

    // input driver: bursts of beats with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                scan_expected.push_back(scan_char(ch, last_char));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (line_chars.size() > 0)
                begin
                    next_beat = line_chars.pop_front();
                    in_valid <= 1'b1;
                    ch <= next_beat.c;
                    last_char <= next_beat.last;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output stall, pattern changes every phase
    always @(posedge clk)
    begin
        if (stall_cycle == STALL_PHASE - 1)
        begin
            stall_cycle <= 0;
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
        end
        else
            stall_cycle <= stall_cycle + 1;
        case (rx_pattern)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:  out_stall <= (stall_cycle % 3 == 0);
        endcase
    end

    // result monitor, each beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_result = {ch_out, in_token, token_start, token_index, char_offset,
                           line_end, token_total};
            if (scan_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("unexpected result beat at %0t", $realtime);
                    show_result("got", seen_result);
                end
            end
            else
            begin
                wanted_result = scan_expected.pop_front();
                if (seen_result !== wanted_result)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("result mismatch at %0t", $realtime);
                        show_result("expected", wanted_result);
                        show_result("got     ", seen_result);
                    end
                end
            end
        end
    end

    initial
    begin
        logic [CHAR_W-1:0] c;
        int unsigned       waited;

        // directed lines: one-char line, operator runs, quotes, other whitespace
        add_char(8'h01, 1'b1);
        add_text(" >><|");
        add_text("a'b >|'c");
        add_text("x\"y 'z");
        add_char(8'h09, 1'b0);
        add_char(8'hff, 1'b0);
        add_char(CH_SPACE, 1'b0);
        add_char(CH_SPACE, 1'b1);

        add_random_lines(RANDOM_CHARS / 2);

        // one long line of alternating operators: saturates the token count
        c = CH_SPACE;
        for (int unsigned i = 0; i < LONG_LINE_CHARS; i++)
        begin
            if (i < OP_TOKEN_CHARS)
                c = (i % 2 == 0) ? CH_GT : CH_LT;
            else
                c = pick_char(c);
            add_char(c, i == LONG_LINE_CHARS - 1);
        end

        add_random_lines(RANDOM_CHARS / 2);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (line_chars.size() != 0 || in_valid)
            @(posedge clk);
        waited = 0;
        while (scan_expected.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);

        if (mismatches == 0 && scan_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
